FILE: rtl/ordered_array_list_engine_macros.svh
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// check that cons holds in the cycle after ante
`define OALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// check that cons holds in the same cycle as ante
`define OALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/oale_pkg.sv
package oale_pkg;

  localparam int DEPTH    = 16;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int ST_W     = 3;
  localparam int FIDX_W   = 4;
  localparam int CAP_W    = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 48;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;
  localparam logic             REG_CAP_IDX = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_INS_FIRST = 3'd1,
    OP_INS_LAST  = 3'd2,
    OP_INS_AT    = 3'd3,
    OP_DELETE    = 3'd4,
    OP_SEARCH    = 3'd5,
    OP_OVERWRITE = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_PUT,
    S_DOWN,
    S_DROP,
    S_SCAN,
    S_FETCH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic up;
    logic put;
    logic down;
    logic drop;
    logic scan;
    logic fetch;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic go;
    logic up_done;
    logic down_done;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/oale_ctrl.sv
module oale_ctrl
  import oale_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.go) begin
          state_nxt = S_RESP;
        end else begin
          case (stat.op)
            OP_READ:      state_nxt = S_FETCH;
            OP_INS_FIRST: state_nxt = S_UP;
            OP_INS_LAST:  state_nxt = S_UP;
            OP_INS_AT:    state_nxt = S_UP;
            OP_DELETE:    state_nxt = S_DOWN;
            OP_SEARCH:    state_nxt = S_SCAN;
            default:      state_nxt = S_RESP;
          endcase
        end
      end
      S_UP: begin
        if (stat.up_done) state_nxt = S_PUT;
      end
      S_PUT:   state_nxt = S_RESP;
      S_DOWN: begin
        if (stat.down_done) state_nxt = S_DROP;
      end
      S_DROP:  state_nxt = S_RESP;
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_RESP;
      end
      S_FETCH: state_nxt = S_RESP;
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_EXEC:  cmd.eval  = 1'b1;
      S_UP:    cmd.up    = 1'b1;
      S_PUT:   cmd.put   = 1'b1;
      S_DOWN:  cmd.down  = 1'b1;
      S_DROP:  cmd.drop  = 1'b1;
      S_SCAN:  cmd.scan  = 1'b1;
      S_FETCH: cmd.fetch = 1'b1;
      S_RESP:  cmd.emit  = stat.out_free;
      default: cmd       = '0;
    endcase
  end

endmodule

FILE: rtl/oale_dpath.sv
`include "ordered_array_list_engine_macros.svh"

module oale_dpath
  import oale_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [CAP_W-1:0]         cap_limit,
  input  logic [OP_W-1:0]          in_opcode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_tready,
  output logic                     out_valid,
  output logic [ST_W-1:0]          out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [FIDX_W-1:0]        out_found_index,
  output logic [CNT_W-1:0]         out_entry_count
);

  logic [DATA_W-1:0] mem [DEPTH];

  op_t               op_r;
  logic [CNT_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [DATA_W-1:0] rdata_r;
  status_t           status_r;
  logic [DATA_W-1:0] rdval_r;
  logic [FIDX_W-1:0] fidx_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [DATA_W-1:0] out_rdval_r;
  logic [FIDX_W-1:0] out_fidx_r;
  logic [CNT_W-1:0]  out_count_r;

  logic [CNT_W-1:0]  eff_cap;
  logic [CNT_W-1:0]  load_pos;
  logic [CNT_W-1:0]  ptr_inc;
  logic              full, pos_lt, pos_le, hit;
  status_t           status_eval;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata;

  always_comb begin
    if (cap_limit == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_limit) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_limit);
    end
  end

  always_comb begin
    case (op_t'(in_opcode))
      OP_INS_FIRST: load_pos = '0;
      OP_INS_LAST:  load_pos = count_r;
      default:      load_pos = CNT_W'(in_position);
    endcase
  end

  assign full    = count_r >= eff_cap;
  assign pos_lt  = pos_r < count_r;
  assign pos_le  = pos_r <= count_r;
  assign ptr_inc = ptr_r + CNT_W'(1);
  assign hit     = pend_r && (rdata_r == val_r);

  always_comb begin
    case (op_r)
      OP_READ:      status_eval = pos_lt ? ST_OK : ST_BADPOS;
      OP_INS_FIRST: status_eval = full ? ST_FULL : ST_OK;
      OP_INS_LAST:  status_eval = full ? ST_FULL : ST_OK;
      OP_INS_AT:    status_eval = full ? ST_FULL : (pos_le ? ST_OK : ST_BADPOS);
      OP_DELETE:    status_eval = (count_r == '0) ? ST_EMPTY :
                                  (pos_lt ? ST_OK : ST_BADPOS);
      OP_SEARCH:    status_eval = ST_NOTFOUND;
      OP_OVERWRITE: status_eval = pos_lt ? ST_OK : ST_BADPOS;
      default:      status_eval = ST_OK;
    endcase
  end

  always_comb begin
    stat.op        = op_r;
    stat.go        = (status_eval == ST_OK) || ((op_r == OP_SEARCH) && (count_r != '0));
    stat.up_done   = ptr_r == pos_r;
    stat.down_done = ptr_inc >= count_r;
    stat.scan_done = hit || (!pend_r && (ptr_r >= count_r));
    stat.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    we            = 1'b0;
    waddr         = pend_addr_r;
    wdata         = rdata_r;
    raddr         = pos_r[ADDR_W-1:0];
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    if (cmd.eval) begin
      case (op_r)
        OP_DELETE: ptr_nxt = pos_r;
        OP_SEARCH: ptr_nxt = '0;
        default:   ptr_nxt = count_r;
      endcase
      if ((op_r == OP_OVERWRITE) && pos_lt) begin
        we    = 1'b1;
        waddr = pos_r[ADDR_W-1:0];
        wdata = val_r;
      end
    end
    if ((cmd.up || cmd.down) && pend_r) begin
      we = 1'b1;
    end
    if (cmd.up && !stat.up_done) begin
      raddr         = ADDR_W'(ptr_r - CNT_W'(1));
      pend_nxt      = 1'b1;
      pend_addr_nxt = ptr_r[ADDR_W-1:0];
      ptr_nxt       = ptr_r - CNT_W'(1);
    end
    if (cmd.down && !stat.down_done) begin
      raddr         = ptr_inc[ADDR_W-1:0];
      pend_nxt      = 1'b1;
      pend_addr_nxt = ptr_r[ADDR_W-1:0];
      ptr_nxt       = ptr_inc;
    end
    if (cmd.scan && (ptr_r < count_r)) begin
      raddr         = ptr_r[ADDR_W-1:0];
      pend_nxt      = 1'b1;
      pend_addr_nxt = ptr_r[ADDR_W-1:0];
      ptr_nxt       = ptr_inc;
    end
    if (cmd.put) begin
      we    = 1'b1;
      waddr = pos_r[ADDR_W-1:0];
      wdata = val_r;
    end
    if (cmd.drop) begin
      we    = 1'b1;
      waddr = ADDR_W'(count_r - CNT_W'(1));
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ptr_r  <= ptr_nxt;
      if (cmd.put) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.drop) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    if (cmd.load) begin
      op_r  <= op_t'(in_opcode);
      pos_r <= load_pos;
      val_r <= in_value;
    end
    if (cmd.eval) begin
      status_r <= status_eval;
      rdval_r  <= ((op_r == OP_READ) && !pos_lt) ? '1 : '0;
      fidx_r   <= '0;
    end
    if (cmd.fetch) begin
      rdval_r <= rdata_r;
    end
    if (cmd.scan && hit) begin
      status_r <= ST_OK;
      fidx_r   <= FIDX_W'(pend_addr_r);
    end
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_rdval_r  <= rdval_r;
      out_fidx_r   <= fidx_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_rdval_r;
  assign out_found_index = out_fidx_r;
  assign out_entry_count = out_count_r;

  `OALE_ASSERT_NEXT(a_put_grows, cmd.put, count_r == $past(count_r) + CNT_W'(1), "put lost")
  `OALE_ASSERT_NEXT(a_drop_shrinks, cmd.drop, count_r == $past(count_r) - CNT_W'(1), "drop lost")
  `OALE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count overflow")
  `OALE_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_r || out_tready, "result overrun")

endmodule

FILE: rtl/ordered_array_list_engine.sv
// Packed list of up to 16 signed 32-bit entries held in a memory with one read and one
// write port and a registered read. One request is taken at a time. Each request is
// loaded and checked; a read then fetches its entry, an insert shifts the entries from
// position upward from the end and writes the value, a delete shifts the entries above
// position down and clears the last, and a search compares from the start to a match;
// an overwrite or a rejected request goes straight to the result, which then waits in
// the output register until taken. Shifts and searches move or compare one entry per
// cycle. capacity_limit sits at byte address 0; 0 acts as 1 and values above 16 as 16.
module ordered_array_list_engine
  import oale_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,     // opcode[2:0], position[7:3], value[39:8]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,    // status[2:0], read_value[34:3],
                                          // found_index[38:35], entry_count[43:39]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [CAP_W-1:0]         cap_r;
  cmd_t                     cmd;
  stat_t                    stat;
  logic [ST_W-1:0]          res_status;
  logic signed [DATA_W-1:0] res_read_value;
  logic [FIDX_W-1:0]        res_found_index;
  logic [CNT_W-1:0]         res_entry_count;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CAP_IDX)) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CAP_IDX) ? APB_DW'(cap_r) : '0;

  oale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oale_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cap_limit       (cap_r),
    .in_opcode       (in_tdata[2:0]),
    .in_position     (in_tdata[7:3]),
    .in_value        (in_tdata[39:8]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (res_status),
    .out_read_value  (res_read_value),
    .out_found_index (res_found_index),
    .out_entry_count (res_entry_count)
  );

  assign out_tdata = {4'b0000, res_entry_count, res_found_index, res_read_value, res_status};

endmodule
